/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the key debounce block; kdlp_core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/core/kdlp_pkg.sv */
// Types and constants of the key debounce and long-press block.
package kdlp_pkg;

    localparam int unsigned PIN_W  = 6;
    localparam int unsigned CODE_W = 3;
    localparam int unsigned DEB_W  = 8;
    localparam int unsigned HOLD_W = 16;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned IDX_W  = 1;

    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 8'd50;
    localparam logic [HOLD_W-1:0] LONG_RESET     = 16'd2000;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code KEY_NONE = 3'd0;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_OPEN     = 2'd0,
        PH_PRESSING = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_OPENING  = 2'd3
    } t_phase;

    typedef struct packed {
        t_code key;
        logic  tick;
    } t_sample;

    typedef struct packed {
        logic  key_held;
        logic  long_press;
        logic  release_event;
        t_code event_key;
    } t_result;

endpackage

/* rtl/core/kdlp_ifs.sv */
// Channel interfaces for key samples, key results and configuration writes.
interface kdlp_key_if;
    import kdlp_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] key_pins;
    logic             tick;
    modport source (output valid, output key_pins, output tick, input ready);
    modport sink (input valid, input key_pins, input tick, output ready);
endinterface

interface kdlp_evt_if;
    import kdlp_pkg::*;
    logic  valid;
    logic  ready;
    logic  key_held;
    logic  long_press;
    logic  release_event;
    t_code event_key;
    modport source (output valid, output key_held, output long_press,
                    output release_event, output event_key, input ready);
    modport sink (input valid, input key_held, input long_press,
                  input release_event, input event_key, output ready);
endinterface

interface kdlp_cfg_if;
    import kdlp_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/kdlp_in_stage.sv */
// Input register stage that priority-encodes the active-low key pins.
module kdlp_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kdlp_key_if.sink          i_key,
    input  logic              i_advance,
    output logic              o_valid,
    output kdlp_pkg::t_sample o_sample
);
    import kdlp_pkg::*;

    logic    r_valid;
    t_sample r_sample;
    t_code   n_key;

    always_comb begin
        n_key = KEY_NONE;
        for (int i = PIN_W - 1; i >= 0; i--) begin
            if (!i_key.key_pins[i]) begin
                n_key = t_code'(i + 1);
            end
        end
    end

    assign i_key.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_key.ready) begin
            r_valid <= i_key.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_sample.key  <= n_key;
            r_sample.tick <= i_key.tick;
        end
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

/* rtl/core/kdlp_core.sv */
// Debounce and hold counters, phase machine, configuration and result register.
module kdlp_core #(
    parameter int unsigned SHORT_BITS = 8,
    parameter int unsigned HOLD_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  kdlp_pkg::t_sample i_sample,
    output logic              o_advance,
    kdlp_cfg_if.sink          i_cfg,
    kdlp_evt_if.source        o_evt
);
    import kdlp_pkg::*;
    `include "assert_macros.svh"

    logic [DEB_W-1:0]      r_debounce;
    logic [HOLD_W-1:0]     r_long;
    t_phase                r_phase, n_phase;
    t_code                 r_held, n_held;
    logic [SHORT_BITS-1:0] r_sc, n_sc;
    logic                  r_se, n_se;
    logic [HOLD_BITS-1:0]  r_hc, n_hc;
    logic                  r_he, n_he;
    logic                  r_down, n_down;
    logic                  r_long_flag, n_long_flag;
    logic                  r_out_valid;
    t_result               r_out, n_out;
    logic                  take;

    assign o_advance   = !r_out_valid || o_evt.ready;
    assign take        = o_advance && i_valid;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_long     <= LONG_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_DEBOUNCE:   r_debounce <= i_cfg.data[DEB_W-1:0];
                CFG_LONG_PRESS: r_long <= i_cfg.data;
                default:        r_long <= r_long;
            endcase
        end
    end

    always_comb begin
        n_sc        = r_sc;
        n_se        = r_se;
        n_hc        = r_hc;
        n_he        = r_he;
        n_phase     = r_phase;
        n_held      = r_held;
        n_down      = r_down;
        n_long_flag = r_long_flag;
        n_out       = '0;
        if (i_sample.tick && !r_se) begin
            n_sc = r_sc - 1'b1;
            n_se = (r_sc == '0);
        end
        if (i_sample.tick && !r_he) begin
            n_hc = r_hc - 1'b1;
            n_he = (r_hc == '0);
        end
        case (r_phase)
            PH_OPEN: begin
                if (i_sample.key != KEY_NONE) begin
                    n_sc    = SHORT_BITS'(r_debounce);
                    n_se    = 1'b0;
                    n_phase = PH_PRESSING;
                    n_held  = i_sample.key;
                end
            end
            PH_PRESSING: begin
                if (i_sample.key != r_held) begin
                    n_phase = PH_OPEN;
                end else if (n_se) begin
                    n_long_flag = 1'b0;
                    n_down      = 1'b1;
                    n_phase     = PH_PRESSED;
                    n_hc        = HOLD_BITS'(r_long);
                    n_he        = 1'b0;
                end
            end
            PH_PRESSED: begin
                if (i_sample.key != r_held) begin
                    n_sc    = SHORT_BITS'(r_debounce);
                    n_se    = 1'b0;
                    n_phase = PH_OPENING;
                end else if (n_he) begin
                    n_long_flag = 1'b1;
                end
            end
            PH_OPENING: begin
                if (i_sample.key == r_held) begin
                    n_phase = PH_PRESSED;
                end else if (n_se) begin
                    n_down              = 1'b0;
                    n_out.release_event = 1'b1;
                    n_out.event_key     = r_held;
                    n_phase             = PH_OPEN;
                end
            end
            default: begin
                n_phase = PH_OPEN;
            end
        endcase
        n_out.key_held   = n_down;
        n_out.long_press = n_long_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OPEN;
            r_held      <= KEY_NONE;
            r_sc        <= '0;
            r_se        <= 1'b1;
            r_hc        <= '0;
            r_he        <= 1'b1;
            r_down      <= 1'b0;
            r_long_flag <= 1'b0;
        end else if (take) begin
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_sc        <= n_sc;
            r_se        <= n_se;
            r_hc        <= n_hc;
            r_he        <= n_he;
            r_down      <= n_down;
            r_long_flag <= n_long_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_evt.valid         = r_out_valid;
    assign o_evt.key_held      = r_out.key_held;
    assign o_evt.long_press    = r_out.long_press;
    assign o_evt.release_event = r_out.release_event;
    assign o_evt.event_key     = r_out.event_key;

    `ASSERT_PROP(a_release_clears_down, i_clk, i_rst_n, !(r_out_valid && r_out.release_event) || !r_out.key_held, "release result still shows the key down")
    `ASSERT_PROP(a_code_only_on_release, i_clk, i_rst_n, !r_out_valid || r_out.event_key == KEY_NONE || r_out.release_event, "key code shown without a release")
    `ASSERT_NEVER(a_down_before_confirm, i_clk, i_rst_n, (r_phase == PH_OPEN || r_phase == PH_PRESSING) && r_down, "key down flag set before a confirmed press")
    `ASSERT_NEVER(a_held_code_valid, i_clk, i_rst_n, r_phase != PH_OPEN && r_held == KEY_NONE, "active phase without a held key")
    `ASSERT_PROP(a_release_from_opening, i_clk, i_rst_n, take && n_out.release_event |-> r_phase == PH_OPENING, "release confirmed outside the release debounce")

endmodule

/* rtl/core/key_debounce_long_press_unit.sv */
// Top level of the six-key debounce reader with long-press detection.
// Each sample is registered in the input stage, and its result in the result register.
// Throughput: one sample per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken.
// Reset: synchronous, active low; the phase machine returns to open, both counters
// read as expired, and the start values return to 50 and 2000 ticks.
module key_debounce_long_press_unit #(
    parameter int unsigned SHORT_BITS = 8,
    parameter int unsigned HOLD_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kdlp_key_if.sink   i_key,
    kdlp_cfg_if.sink   i_cfg,
    kdlp_evt_if.source o_evt
);
    import kdlp_pkg::*;

    logic    s_valid;
    logic    s_advance;
    t_sample s_sample;

    kdlp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_key),
        .i_advance (s_advance),
        .o_valid   (s_valid),
        .o_sample  (s_sample)
    );

    kdlp_core #(
        .SHORT_BITS (SHORT_BITS),
        .HOLD_BITS  (HOLD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_valid),
        .i_sample  (s_sample),
        .o_advance (s_advance),
        .i_cfg     (i_cfg),
        .o_evt     (o_evt)
    );

endmodule
